/* rtl/ouel_pkg.sv */
package ouel_pkg;

	localparam int LIST_SIZE = 32;
	localparam int CNT_W     = $clog2(LIST_SIZE + 1);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_FULL     = 3'd5,
		ST_OK       = 3'd6
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic             go;
		op_t              op;
		logic [7:0]       value;
		logic [4:0]       pos;
		logic [CNT_W-1:0] count;
		logic             present;
	} cell_cmd_t;

endpackage

/* rtl/ouel_cell.sv */
module ouel_cell
	import ouel_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [CNT_W-1:0] idx,
	input  logic [7:0]       next_entry,
	input  logic             match_in,
	output logic             match_out,
	input  logic [7:0]       rd_in,
	output logic [7:0]       rd_out,
	output logic [7:0]       entry
);

	logic [7:0] entry_q;
	logic       valid;
	logic       hit;
	logic       sel;

	assign valid     = idx < cmd.count;
	assign hit       = valid && (entry_q == cmd.value);
	assign match_out = match_in | hit;
	assign sel       = valid && (idx == CNT_W'(cmd.pos));
	assign rd_out    = rd_in | (sel ? entry_q : 8'd0);
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= 8'd0;
		end else if (cmd.go) begin
			case (cmd.op)
				OP_ADD: begin
					if (!cmd.present && idx == cmd.count) begin
						entry_q <= cmd.value;
					end
				end
				OP_DEL: begin
					// close the gap: cells from the hit onwards take their neighbour
					if (cmd.present && match_out) begin
						entry_q <= next_entry;
					end
				end
				OP_CLEAR: begin
					entry_q <= 8'd0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/ordered_unique_list_engine.sv */
// Ordered unique list engine.
// Input stream s_*: one word per command, tdata holds opcode (add unique,
// delete value, clear, read position), the value and the read position.
// Output stream m_*: one word per command with status, entry count after the
// command and read data (zero unless a read inside the list).
// The list lives in a row of LIST_SIZE cells; each compares its entry with
// the broadcast value, a match flag ripples along the row and on delete every
// cell from the hit onwards loads its neighbour, so compaction is one step.
// Timing: an accepted word is registered and the state moves to execute; the
// command executes once the output register is free; its result is registered there.
// A new command is not accepted until the previous one has executed (S_IDLE, S_EXEC).
// s_tready is low while a command executes. If the receiver stalls, the
// result waits in the output register; one further command is accepted and
// then holds in execute until the output register is free.
// Reset: list empty, count zero, all entries zero, no pending output.
module ordered_unique_list_engine
	import ouel_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // opcode[1:0], item_value[9:2], read_position[14:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[2:0], entry_count[8:3], read_data[16:9]
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [7:0]       value_q;
	logic [4:0]       pos_q;
	logic [CNT_W-1:0] count_q;
	logic             m_valid_q;
	status_t          status_q;
	logic [5:0]       ocount_q;
	logic [7:0]       rdata_q;

	logic             go;
	logic             present;
	status_t          status_d;
	logic [CNT_W-1:0] count_d;
	cell_cmd_t        cmd;

	logic [7:0] entry [LIST_SIZE+1];
	logic       match [LIST_SIZE+1];
	logic [7:0] rd    [LIST_SIZE+1];

	assign s_tready = (state_q == S_IDLE);
	assign go       = (state_q == S_EXEC) && (!m_valid_q || m_tready);

	assign entry[LIST_SIZE] = 8'd0;
	assign match[0]         = 1'b0;
	assign rd[0]            = 8'd0;
	assign present          = match[LIST_SIZE];

	assign cmd.go      = go;
	assign cmd.op      = op_q;
	assign cmd.value   = value_q;
	assign cmd.pos     = pos_q;
	assign cmd.count   = count_q;
	assign cmd.present = present;

	for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
		ouel_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.idx        (CNT_W'(i)),
			.next_entry (entry[i+1]),
			.match_in   (match[i]),
			.match_out  (match[i+1]),
			.rd_in      (rd[i]),
			.rd_out     (rd[i+1]),
			.entry      (entry[i])
		);
	end

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		case (op_q)
			OP_ADD: begin
				if (present) begin
					status_d = ST_PRESENT;
				end else if (count_q == CNT_W'(LIST_SIZE)) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_ADDED;
					count_d  = count_q + 1'b1;
				end
			end
			OP_DEL: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (!present) begin
					status_d = ST_NOTFOUND;
				end else begin
					status_d = ST_REMOVED;
					count_d  = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= S_IDLE;
						count_q <= count_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= op_t'(s_tdata[1:0]);
			value_q <= s_tdata[9:2];
			pos_q   <= s_tdata[14:10];
		end
		if (go) begin
			status_q <= status_d;
			ocount_q <= 6'(count_d);
			rdata_q  <= (op_q == OP_READ) ? rd[LIST_SIZE] : 8'd0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, rdata_q, ocount_q, status_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_SIZE))
		else $error("entry count above list size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while executing");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(go && status_d == ST_REMOVED) |=> (count_q == $past(count_q) - 1'b1))
		else $error("removal did not shrink the list by one");

	a_result_on_go: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> m_tvalid)
		else $error("executed command left no result");

endmodule
